/* rtl/psg_pkg.sv */
// Shared types and constants of the programmable sound generator.
package psg_pkg;

  typedef enum logic [1:0] {
    FUNC_ADDR  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

  localparam int unsigned NumRegs     = 16;
  localparam int unsigned MaxChannels = 3;

  // Register map
  localparam logic [3:0] RegNoisePer = 4'd6;
  localparam logic [3:0] RegMixer    = 4'd7;
  localparam logic [3:0] RegVolBase  = 4'd8;
  localparam logic [3:0] RegEnvLo    = 4'd11;
  localparam logic [3:0] RegEnvHi    = 4'd12;
  localparam logic [3:0] RegShape    = 4'd13;

  // Shape register bits
  localparam int unsigned ShapeAttack = 1;
  localparam int unsigned ShapeAlt    = 2;
  localparam int unsigned ShapeHold   = 3;

  // Volume register bit that selects the envelope
  localparam int unsigned VolEnvSel = 4;

  localparam logic [16:0] NoiseSeed = 17'h10000;
  localparam logic [4:0]  EnvLast   = 5'd31;

endpackage

/* rtl/psg_in_if.sv */
// Request channel of the sound generator: function code and value byte.
interface psg_in_if;
  import psg_pkg::*;

  logic        valid;
  logic        ready;
  func_e       func;
  logic [7:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

/* rtl/psg_out_if.sv */
// Result channel of the sound generator: read byte and channel levels.
interface psg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [3:0]  chan_a_level;
  logic [3:0]  chan_b_level;
  logic [3:0]  chan_c_level;
  logic [5:0]  mix_level;

  modport source (output valid, output read_data, output chan_a_level,
                  output chan_b_level, output chan_c_level, output mix_level,
                  input ready);
  modport sink   (input valid, input read_data, input chan_a_level,
                  input chan_b_level, input chan_c_level, input mix_level,
                  output ready);
endinterface

/* rtl/psg_tone_noise_envelope.sv */
// Top level of the three-channel tone, noise and envelope sound generator.
//
// Usage:
//   in_i carries one request per transfer: func selects an address-latch
//   write, a register write, a register read or one generator tick, and
//   value holds the address (low nibble) or the data byte.
//   out_o returns exactly one result per request: the read byte (zero for
//   anything but a read) and the channel levels and their sum as they stand
//   once the request has taken effect.
// Timing and throughput:
//   A request updates the register file, dividers, LFSR and envelope at the
//   edge it is accepted, and its result is loaded into the output register at
//   that same edge, so out_o.valid rises in the cycle after acceptance. One
//   request per cycle is sustained while out_o.ready stays high; the single
//   output register sets this, as the next request is taken in the cycle its
//   predecessor's result is transferred.
// Stalls:
//   While out_o.ready is low and a result is held, in_i.ready drops; the
//   held result stays stable until transferred.
// Reset:
//   rst_ni clears the register file, address latch, all dividers and the
//   envelope, and loads the noise LFSR with its seed. No result is pending.
module psg_tone_noise_envelope #(
  parameter int unsigned CHANNELS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psg_in_if.sink     in_i,
  psg_out_if.source  out_o
);
  import psg_pkg::*;

  logic [7:0]  reg_file_q [NumRegs];
  logic [7:0]  reg_file_d [NumRegs];
  logic [3:0]  addr_latch_q, addr_latch_d;
  logic [4:0]  noise_count_q, noise_count_d;
  logic [16:0] noise_shift_q, noise_shift_d;
  logic        noise_level_q, noise_level_d;
  logic [15:0] env_count_q, env_count_d;
  logic [4:0]  env_step_q, env_step_d;
  logic        env_hold_q, env_hold_d;
  logic        tone_level_d [MaxChannels];

  logic        in_fire;
  logic        do_tick;
  logic        out_valid_q;
  logic [7:0]  read_data_q, read_data_d;
  logic [3:0]  level_q [MaxChannels];
  logic [3:0]  level_d [MaxChannels];
  logic [5:0]  mix_q, mix_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign do_tick    = in_fire && (in_i.func == FUNC_TICK);

  // Register file and address latch
  always_comb begin
    reg_file_d   = reg_file_q;
    addr_latch_d = addr_latch_q;
    read_data_d  = 8'd0;
    if (in_fire) begin
      case (in_i.func)
        FUNC_ADDR:  addr_latch_d = in_i.value[3:0];
        FUNC_WRITE: reg_file_d[addr_latch_q] = in_i.value;
        FUNC_READ:  read_data_d = reg_file_q[addr_latch_q];
        default:    ;
      endcase
    end
  end

  // Tone dividers, one per implemented channel
  for (genvar g = 0; g < MaxChannels; g++) begin : g_tone
    if (g < CHANNELS) begin : g_on
      logic [11:0] count_q, count_d, period;
      logic        tone_q;

      assign period = {reg_file_q[2*g+1][3:0], reg_file_q[2*g]};

      always_comb begin
        count_d         = count_q;
        tone_level_d[g] = tone_q;
        if (do_tick) begin
          if (count_q == 12'd0) begin
            count_d         = (period == 12'd0) ? 12'd1 : period;
            tone_level_d[g] = !tone_q;
          end else begin
            count_d = count_q - 12'd1;
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          count_q <= '0;
          tone_q  <= 1'b0;
        end else begin
          count_q <= count_d;
          tone_q  <= tone_level_d[g];
        end
      end
    end else begin : g_off
      assign tone_level_d[g] = 1'b0;
    end
  end

  // Noise divider and LFSR
  always_comb begin
    noise_count_d = noise_count_q;
    noise_shift_d = noise_shift_q;
    noise_level_d = noise_level_q;
    if (do_tick) begin
      if (noise_count_q == 5'd0) begin
        noise_count_d = (reg_file_q[RegNoisePer][4:0] == 5'd0) ?
                        5'd1 : reg_file_q[RegNoisePer][4:0];
        noise_shift_d = {noise_shift_q[0] ^ noise_shift_q[3], noise_shift_q[16:1]};
        noise_level_d = noise_shift_d[0];
      end else begin
        noise_count_d = noise_count_q - 5'd1;
      end
    end
  end

  // Envelope divider and step
  logic [15:0] env_period;
  assign env_period = {reg_file_q[RegEnvHi], reg_file_q[RegEnvLo]};

  always_comb begin
    env_count_d = env_count_q;
    env_step_d  = env_step_q;
    env_hold_d  = env_hold_q;
    if (do_tick && !env_hold_q) begin
      if (env_count_q == 16'd0) begin
        env_count_d = (env_period == 16'd0) ? 16'd1 : env_period;
        if (env_step_q != EnvLast) begin
          env_step_d = env_step_q + 5'd1;
        end else if (reg_file_q[RegShape][ShapeHold]) begin
          env_hold_d = 1'b1;
          if (reg_file_q[RegShape][ShapeAlt]) begin
            env_step_d = EnvLast - env_step_q;
          end
        end else begin
          env_step_d = 5'd0;
        end
      end else begin
        env_count_d = env_count_q - 16'd1;
      end
    end
  end

  // Envelope amplitude from the updated step and shape
  logic [3:0] env_amp;
  logic [2:0] env_half;
  logic       shp_attack, shp_alt;

  assign env_half   = env_step_d[3:1];
  assign shp_attack = reg_file_d[RegShape][ShapeAttack];
  assign shp_alt    = reg_file_d[RegShape][ShapeAlt];

  always_comb begin
    if (!env_step_d[4]) begin
      env_amp = shp_attack ? {1'b0, env_half} : 4'd15 - {1'b0, env_half};
    end else if (shp_alt) begin
      env_amp = shp_attack ? 4'd15 - {1'b0, env_half} : {1'b0, env_half};
    end else begin
      env_amp = shp_attack ? 4'd15 : 4'd0;
    end
  end

  // Channel levels and mix
  always_comb begin
    logic [7:0] vol;
    logic [3:0] amp;
    logic       t_on, n_on;
    mix_d = 6'd0;
    for (int ch = 0; ch < MaxChannels; ch++) begin
      vol  = reg_file_d[RegVolBase + 4'(ch)];
      amp  = vol[VolEnvSel] ? env_amp : vol[3:0];
      t_on = !reg_file_d[RegMixer][ch] && tone_level_d[ch];
      n_on = !reg_file_d[RegMixer][ch+3] && noise_level_d;
      level_d[ch] = (ch < CHANNELS && (t_on || n_on)) ? amp : 4'd0;
      mix_d = mix_d + 6'(level_d[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        reg_file_q[i] <= 8'd0;
      end
      addr_latch_q  <= '0;
      noise_count_q <= '0;
      noise_shift_q <= NoiseSeed;
      noise_level_q <= 1'b0;
      env_count_q   <= '0;
      env_step_q    <= '0;
      env_hold_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      reg_file_q    <= reg_file_d;
      addr_latch_q  <= addr_latch_d;
      noise_count_q <= noise_count_d;
      noise_shift_q <= noise_shift_d;
      noise_level_q <= noise_level_d;
      env_count_q   <= env_count_d;
      env_step_q    <= env_step_d;
      env_hold_q    <= env_hold_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register, loaded on every accepted request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_data_q <= read_data_d;
      level_q     <= level_d;
      mix_q       <= mix_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.read_data    = read_data_q;
  assign out_o.chan_a_level = level_q[0];
  assign out_o.chan_b_level = level_q[1];
  assign out_o.chan_c_level = level_q[2];
  assign out_o.mix_level    = mix_q;

  // Once held, the envelope is never released
  a_env_hold_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_hold_q |=> env_hold_q)
    else $error("envelope hold released");

  // The LFSR can never fall into the all-zero lock-up state
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_shift_q != 17'd0)
    else $error("noise LFSR reached zero");

  // Held mix must match the held channel levels
  a_mix_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> mix_q == 6'(level_q[0]) + 6'(level_q[1]) + 6'(level_q[2]))
    else $error("mix level does not match channel levels");

  // A non-read request yields a zero read byte
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.func != FUNC_READ) |=> read_data_q == 8'd0)
    else $error("read byte on non-read transfer");

  // Dividers and envelope only move on a tick
  a_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_tick |=> $stable(noise_shift_q) && $stable(env_step_q))
    else $error("generator state moved without a tick");

endmodule

/* test/psg_tone_noise_envelope_tb.sv */
// Self-checking testbench for the tone, noise and envelope sound generator.
`timescale 1ns / 1ps

module psg_tone_noise_envelope_tb;
  import psg_pkg::*;

  localparam int unsigned NumChans      = 3;
  localparam logic [3:0]  RegToneBase   = 4'd0;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 225;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] chan_a;
    logic [3:0] chan_b;
    logic [3:0] chan_c;
    logic [5:0] mix;
  } psg_sample_t;

  // Predicts the read byte and channel levels of every request, in order.
  class psg_checker;
    logic [7:0]  regs [NumRegs];
    logic [3:0]  addr;
    logic [11:0] tone_cnt [MaxChannels];
    logic        tone_lvl [MaxChannels];
    logic [4:0]  noise_cnt;
    logic [16:0] lfsr;
    logic        noise_lvl;
    logic [15:0] env_cnt;
    logic [4:0]  env_pos;
    bit          env_frozen;
    psg_sample_t sample_queue [$];
    int unsigned errors;
    int unsigned compared;
    int unsigned n_ticks, n_reads, n_writes;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (tone_cnt[i]) begin
        tone_cnt[i] = '0;
        tone_lvl[i] = 1'b0;
      end
      addr       = '0;
      noise_cnt  = '0;
      lfsr       = NoiseSeed;
      noise_lvl  = 1'b0;
      env_cnt    = '0;
      env_pos    = '0;
      env_frozen = 1'b0;
    endfunction

    function logic [3:0] env_amplitude();
      logic attack, alt;
      logic [3:0] half;
      attack = regs[RegShape][ShapeAttack];
      alt    = regs[RegShape][ShapeAlt];
      half   = {1'b0, env_pos[3:1]};
      if (!env_pos[4]) return attack ? half : 4'd15 - half;
      if (alt) return attack ? 4'd15 - half : half;
      return attack ? 4'd15 : 4'd0;
    endfunction

    function logic [3:0] level_of(int ch);
      logic [7:0] vol;
      logic [3:0] amp;
      logic tone_on, noise_on;
      if (ch >= NumChans) return 4'd0;
      vol      = regs[RegVolBase + ch];
      amp      = vol[VolEnvSel] ? env_amplitude() : vol[3:0];
      tone_on  = !regs[RegMixer][ch] && tone_lvl[ch];
      noise_on = !regs[RegMixer][ch + 3] && noise_lvl;
      return (tone_on || noise_on) ? amp : 4'd0;
    endfunction

    function void run_tick();
      logic [11:0] per;
      logic [15:0] env_per;
      logic fb;
      for (int ch = 0; ch < NumChans; ch++) begin
        if (tone_cnt[ch] == 0) begin
          per = {regs[RegToneBase + 2 * ch + 1][3:0], regs[RegToneBase + 2 * ch]};
          tone_cnt[ch] = (per == 0) ? 12'd1 : per;
          tone_lvl[ch] = ~tone_lvl[ch];
        end else begin
          tone_cnt[ch] = tone_cnt[ch] - 12'd1;
        end
      end
      if (noise_cnt == 0) begin
        noise_cnt = (regs[RegNoisePer][4:0] == 0) ? 5'd1 : regs[RegNoisePer][4:0];
        fb        = lfsr[0] ^ lfsr[3];
        lfsr      = {fb, lfsr[16:1]};
        noise_lvl = lfsr[0];
      end else begin
        noise_cnt = noise_cnt - 5'd1;
      end
      if (!env_frozen) begin
        if (env_cnt == 0) begin
          env_per = {regs[RegEnvHi], regs[RegEnvLo]};
          env_cnt = (env_per == 0) ? 16'd1 : env_per;
          if (env_pos != EnvLast) begin
            env_pos = env_pos + 5'd1;
          end else if (regs[RegShape][ShapeHold]) begin
            env_frozen = 1'b1;
            if (regs[RegShape][ShapeAlt]) env_pos = EnvLast - env_pos;
          end else begin
            env_pos = '0;
          end
        end else begin
          env_cnt = env_cnt - 16'd1;
        end
      end
    endfunction

    function void take_request(func_e f, logic [7:0] v);
      psg_sample_t s;
      s = '0;
      case (f)
        FUNC_ADDR:  addr = v[3:0];
        FUNC_WRITE: begin
          regs[addr] = v;
          n_writes++;
        end
        FUNC_READ: begin
          s.read_data = regs[addr];
          n_reads++;
        end
        default: begin
          run_tick();
          n_ticks++;
        end
      endcase
      s.chan_a = level_of(0);
      s.chan_b = level_of(1);
      s.chan_c = level_of(2);
      s.mix    = 6'(s.chan_a) + 6'(s.chan_b) + 6'(s.chan_c);
      sample_queue.push_back(s);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_sample(psg_sample_t got);
      psg_sample_t want;
      if (sample_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transfer, none outstanding, actual %h",
                 $time, got);
        return;
      end
      want = sample_queue.pop_front();
      compared++;
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("chan_a_level", 8'(want.chan_a), 8'(got.chan_a));
      compare_field("chan_b_level", 8'(want.chan_b), 8'(got.chan_b));
      compare_field("chan_c_level", 8'(want.chan_c), 8'(got.chan_c));
      compare_field("mix_level", 8'(want.mix), 8'(got.mix));
    endfunction

    function int pending();
      return sample_queue.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  psg_in_if  in_bus ();
  psg_out_if out_bus ();

  psg_tone_noise_envelope uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  psg_checker  sb = new();
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned sent;
  int unsigned idle_cycles = 0;
  bit          hold_ok;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor and watchdog: results are checked before the request of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_sample({out_bus.read_data, out_bus.chan_a_level, out_bus.chan_b_level,
                         out_bus.chan_c_level, out_bus.mix_level});
      if (in_bus.valid && in_bus.ready) sb.take_request(in_bus.func, in_bus.value);
      if ((out_bus.valid && out_bus.ready) || (in_bus.valid && in_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d samples outstanding", $time, sb.pending());
        $display("psg_tone_noise_envelope_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send(func_e f, logic [7:0] v);
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.func  <= f;
    in_bus.value <= v;
    do @(posedge clk_i); while (!in_bus.ready);
    sent++;
  endtask

  // Data biased so that dividers and the envelope turn over often
  function automatic logic [7:0] pick_data(logic [3:0] idx);
    logic [7:0] d;
    d = 8'($urandom);
    if (idx < RegNoisePer) begin
      if ($urandom_range(0, 99) < 85) begin
        if (idx[0]) d[3:0] = '0;
        else d[7:3] = '0;
      end
    end else if (idx == RegEnvLo) begin
      if ($urandom_range(0, 99) < 90) d[7:3] = '0;
    end else if (idx == RegEnvHi) begin
      if ($urandom_range(0, 99) < 90) d = '0;
    end else if (idx == RegShape) begin
      if (!hold_ok || $urandom_range(0, 99) < 70) d[ShapeHold] = 1'b0;
    end
    return d;
  endfunction

  task automatic random_op();
    logic [3:0] idx;
    int unsigned r;
    r   = $urandom_range(0, 99);
    idx = 4'($urandom);
    if (r < 55) begin
      send(FUNC_TICK, 8'($urandom));
    end else if (r < 80) begin
      send(FUNC_ADDR, {4'($urandom), idx});
      send(FUNC_WRITE, pick_data(idx));
    end else if (r < 92) begin
      send(FUNC_ADDR, {4'($urandom), idx});
      send(FUNC_READ, 8'($urandom));
    end else begin
      // stray request against whatever address is latched
      send(func_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned count);
    int unsigned target;
    target    = sent + count;
    gap_pct   = gap;
    stall_pct = stall;
    while (sent < target) random_op();
  endtask

  task automatic directed();
    send(FUNC_READ, 8'h00);
    send(FUNC_TICK, 8'hFF);       // zero periods count as one
    send(FUNC_ADDR, {4'hF, RegMixer});
    send(FUNC_WRITE, 8'h00);
    send(FUNC_ADDR, {4'h0, RegVolBase});
    send(FUNC_WRITE, 8'h0F);
    send(FUNC_ADDR, {4'h0, RegVolBase + 4'd1});
    send(FUNC_WRITE, 8'h1F);
    send(FUNC_ADDR, {4'h0, RegVolBase + 4'd2});
    send(FUNC_WRITE, 8'hFF);
    send(FUNC_ADDR, {4'hA, RegShape});
    send(FUNC_WRITE, 8'hF7);      // hold clear
    send(FUNC_ADDR, {4'h5, RegToneBase + 4'd1});
    send(FUNC_WRITE, 8'hFF);
    send(FUNC_WRITE, 8'hF0);      // upper nibble of tone high is ignored
    send(FUNC_READ, 8'h00);
    repeat (6) send(FUNC_TICK, 8'h00);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.func   = FUNC_TICK;
    in_bus.value  = '0;
    gap_pct       = 0;
    stall_pct     = 0;
    sent          = 0;
    hold_ok       = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed();
    run_phase(0, 0, PhaseItems);
    run_phase(57, 0, PhaseItems);
    run_phase(0, 57, PhaseItems);
    hold_ok = 1'b1;
    run_phase(23, 23, PhaseItems);

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d requests: %0d ticks, %0d register writes, %0d reads.",
             sent, sb.n_ticks, sb.n_writes, sb.n_reads);
    $display("Compared %0d output samples; envelope hold reached: %s.",
             sb.compared, sb.env_frozen ? "yes" : "no");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("psg_tone_noise_envelope_tb OK");
    end else begin
      $display("psg_tone_noise_envelope_tb NOT OK");
    end
    $finish;
  end

endmodule
